// ===== design/fir_filter_eight_tap_assert.svh =====
// Assertion macros shared by the FIR filter RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef FIR_FILTER_EIGHT_TAP_ASSERT_SVH
`define FIR_FILTER_EIGHT_TAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fte_pkg.sv =====
// Types and constants of the eight-tap FIR filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fte_pkg;

	localparam int MAX_TAPS   = 8;
	localparam int TAPS       = 8;
	localparam int HIST_DEPTH = MAX_TAPS - 1;
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int PAIR_W     = PROD_W + 1;
	localparam int QUAD_W     = PROD_W + 2;
	localparam int ACC_W      = PROD_W + 3;
	localparam int FRAC_BITS  = 14;
	localparam int RES_W      = ACC_W - FRAC_BITS;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = $clog2(MAX_TAPS);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
	localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(32768);

	localparam logic signed [SAMPLE_W-1:0] COEF0_RESET = SAMPLE_W'(16384);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [PAIR_W-1:0]   pair_t;
	typedef logic signed [QUAD_W-1:0]   quad_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [RES_W-1:0]    res_t;

	typedef sample_t coef_arr_t [MAX_TAPS];
	typedef prod_t   prod_arr_t [MAX_TAPS];

	// Load enables of the adder stages behind the tap cells.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

// ===== design/fte_cfg.sv =====
// APB coefficient register file of the FIR filter.
// Depends on fte_pkg.
`timescale 1ns / 1ps

module fte_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fte_pkg::ADDR_W-1:0] paddr,
	input  logic [fte_pkg::DATA_W-1:0] pwdata,
	output logic [fte_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output fte_pkg::coef_arr_t         coef
);
	import fte_pkg::*;

	sample_t          coef_q [MAX_TAPS];
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[IDX_W+1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Tap 0 comes out of reset at 1.0, so the filter starts as a pass-through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				coef_q[k] <= (k == 0) ? COEF0_RESET : '0;
			end
		end else if (wr_en) begin
			coef_q[idx] <= sample_t'(pwdata[SAMPLE_W-1:0]);
		end
	end

	assign prdata = {{(DATA_W - SAMPLE_W){1'b0}}, coef_q[idx]};

	always_comb begin
		for (int k = 0; k < MAX_TAPS; k++) begin
			coef[k] = coef_q[k];
		end
	end

endmodule

// ===== design/fte_tap_cell.sv =====
// One tap of the FIR delay line: multiplies the sample passing in and
// holds it for the next tap. Depends on fte_pkg.
`timescale 1ns / 1ps

module fte_tap_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic             clear,
	input  fte_pkg::sample_t x_in,
	input  fte_pkg::sample_t coef,
	output fte_pkg::sample_t x_out,
	output fte_pkg::prod_t   prod_s1
);
	import fte_pkg::*;

	sample_t hist_q;

	// The delay register is filter state; a last item empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift_en) begin
			hist_q <= clear ? sample_t'(0) : x_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			prod_s1 <= PROD_W'(x_in) * PROD_W'(coef);
		end
	end

	assign x_out = hist_q;

endmodule

// ===== design/fte_acc.sv =====
// Registered adder tree, rounding and saturation of the FIR filter.
// Depends on fte_pkg.
`timescale 1ns / 1ps

module fte_acc (
	input  logic                 clk,
	input  fte_pkg::adv_t        adv,
	input  fte_pkg::prod_arr_t   prod_s1,
	input  logic                 last_s1,
	output fte_pkg::sample_t     filtered,
	output logic                 sat,
	output logic                 last
);
	import fte_pkg::*;

	pair_t   pair_s2 [MAX_TAPS/2];
	quad_t   quad_s3 [MAX_TAPS/4];
	acc_t    sum_s4;
	sample_t filt_s5;
	logic    sat_s5;
	logic    last_s2, last_s3, last_s4, last_s5;
	acc_t    rounded;
	res_t    res;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < MAX_TAPS/2; k++) begin
				pair_s2[k] <= PAIR_W'(prod_s1[2*k]) + PAIR_W'(prod_s1[2*k+1]);
			end
			last_s2 <= last_s1;
		end
		if (adv.s3) begin
			for (int k = 0; k < MAX_TAPS/4; k++) begin
				quad_s3[k] <= QUAD_W'(pair_s2[2*k]) + QUAD_W'(pair_s2[2*k+1]);
			end
			last_s3 <= last_s2;
		end
		if (adv.s4) begin
			sum_s4  <= ACC_W'(quad_s3[0]) + ACC_W'(quad_s3[1]);
			last_s4 <= last_s3;
		end
		if (adv.s5) begin
			if (res > RES_MAX) begin
				filt_s5 <= sample_t'(RES_MAX);
				sat_s5  <= 1'b1;
			end else if (res < RES_MIN) begin
				filt_s5 <= sample_t'(RES_MIN);
				sat_s5  <= 1'b1;
			end else begin
				filt_s5 <= sample_t'(res);
				sat_s5  <= 1'b0;
			end
			last_s5 <= last_s4;
		end
	end

	// Round half up, then floor by dropping the fraction bits.
	assign rounded = sum_s4 + ROUND_HALF;
	assign res     = res_t'(rounded[ACC_W-1:FRAC_BITS]);

	assign filtered = filt_s5;
	assign sat      = sat_s5;
	assign last     = last_s5;

endmodule

// ===== design/fir_filter_eight_tap.sv =====
// Eight-tap direct-form FIR filter, signed Q2.14 in and out.
// An accepted item is registered in s1 and moves on through s2, s3 and s4 to s5.
// Throughput: one item per clock; each stage holds while the next is full.
// Reset clears the delay line and the stage valid bits and sets coef_0 to 1.0.
// Depends on fte_pkg, fte_cfg, fte_tap_cell, fte_acc and the assertion header.
`timescale 1ns / 1ps
`include "fir_filter_eight_tap_assert.svh"

module fir_filter_eight_tap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fte_pkg::ADDR_W-1:0] paddr,
	input  logic [fte_pkg::DATA_W-1:0] pwdata,
	output logic [fte_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  fte_pkg::sample_t           sample_in,
	input  logic                       last_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output fte_pkg::sample_t           filtered_out,
	output logic                       last_out,
	output logic                       saturated
);
	import fte_pkg::*;

	// The pipeline is a row of tap cells followed by a registered adder tree:
	//   s1: each tap cell registers its product, and the delay line shifts.
	//   s2..s4: pairwise sums, three levels for eight taps.
	//   s5: round half up, saturate, and hold the result for the consumer.
	// Each stage takes a new item whenever it is empty or its successor moves,
	// so bubbles close up and input is still taken while a result waits.

	coef_arr_t coef;
	sample_t   coef_tap [MAX_TAPS];
	sample_t   tap_x    [MAX_TAPS];
	prod_arr_t prod_s1;
	adv_t      adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic last_s1;
	logic in_accept;
	logic hist_zero;

	fte_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	// Backward ready chain: a stage can load if it is empty or drains this cycle.
	assign rdy_s5    = !vld_s5 || out_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign in_accept = in_valid && in_ready;

	assign adv.s2 = rdy_s2 && vld_s1;
	assign adv.s3 = rdy_s3 && vld_s2;
	assign adv.s4 = rdy_s4 && vld_s3;
	assign adv.s5 = rdy_s5 && vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			last_s1 <= last_in;
		end
	end

	// The current sample enters tap 0; each cell hands its held sample to the
	// next tap, so cell j multiplies the sample j items back. A last item
	// clears every cell, which starts the next signal with zero history.
	assign tap_x[0] = sample_in;

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
		if (j < TAPS) begin : g_used
			assign coef_tap[j] = coef[j];
		end else begin : g_unused
			assign coef_tap[j] = '0;
		end

		if (j < MAX_TAPS - 1) begin : g_mid
			fte_tap_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_accept),
				.clear    (last_in),
				.x_in     (tap_x[j]),
				.coef     (coef_tap[j]),
				.x_out    (tap_x[j+1]),
				.prod_s1  (prod_s1[j])
			);
		end else begin : g_end
			fte_tap_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_accept),
				.clear    (last_in),
				.x_in     (tap_x[j]),
				.coef     (coef_tap[j]),
				.x_out    (),
				.prod_s1  (prod_s1[j])
			);
		end
	end

	fte_acc u_acc (
		.clk      (clk),
		.adv      (adv),
		.prod_s1  (prod_s1),
		.last_s1  (last_s1),
		.filtered (filtered_out),
		.sat      (saturated),
		.last     (last_out)
	);

	assign out_valid = vld_s5;

	always_comb begin
		hist_zero = 1'b1;
		for (int k = 1; k < MAX_TAPS; k++) begin
			if (tap_x[k] != '0) begin
				hist_zero = 1'b0;
			end
		end
	end

	`FTE_ASSERT_NEXT(a_last_clears, in_accept && last_in, hist_zero,
		"delay line not cleared after a last item")
	`FTE_ASSERT_NEXT(a_shift_in, in_accept && !last_in, tap_x[1] == $past(sample_in),
		"accepted sample did not enter the delay line")
	`FTE_ASSERT_NOW(a_empty_ready, !vld_s5, in_ready,
		"input stalled while the output register is empty")
	`FTE_ASSERT_NOW(a_sat_rail, out_valid && saturated,
		filtered_out == sample_t'(RES_MAX) || filtered_out == sample_t'(RES_MIN),
		"saturated result is not at a rail")

endmodule
